FILE: src/sjf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared types, codes and helpers for the shortest-job-first scheduler core.
// ----------------------------------------------------------------------------
package sjf_pkg;

  // Default table depth.
  localparam int DEF_MAX_JOBS = 16;

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result event codes.
  localparam logic [1:0] EV_IDLE = 2'd0;
  localparam logic [1:0] EV_RUN  = 2'd1;
  localparam logic [1:0] EV_DONE = 2'd2;

  localparam logic [15:0] TIME_MAX = 16'hFFFF;
  localparam logic [15:0] SWITCH_MAX = 16'hFFFF;

  // One request on the input channel.
  typedef struct packed {
    logic        req_type;
    logic [7:0]  job_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
  } sjf_req_t;

  // One result on the output channel.
  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  run_id;
    logic        dispatched;
    logic [15:0] ticks_left;
    logic [15:0] tick_start;
    logic [15:0] tick_end;
    logic [15:0] switch_count;
    logic        all_done;
  } sjf_res_t;

  // Best candidate travelling down the cell chain.
  typedef struct packed {
    logic        valid;
    logic [15:0] burst;
    logic [15:0] arrival;
    logic [7:0]  id;
  } sjf_cand_t;

  // Control strobes from the sequencer to every cell.
  typedef struct packed {
    logic load_en;
    logic finish_en;
  } sjf_cell_ctl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } sjf_state_t;

  // True when a is strictly better than b: shorter burst, then earlier
  // arrival, then lower id.
  function automatic logic sjf_better(sjf_cand_t a, sjf_cand_t b);
    logic res;
    if (a.burst != b.burst) begin
      res = (a.burst < b.burst);
    end else if (a.arrival != b.arrival) begin
      res = (a.arrival < b.arrival);
    end else begin
      res = (a.id < b.id);
    end
    return res;
  endfunction

endpackage

FILE: src/shortest_job_first_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_core
// Non-preemptive shortest-job-first scheduler advanced one tick per tick request.
// ----------------------------------------------------------------------------
// A load request gives no result. A tick request while a job holds the
// processor goes straight to the execute state. A tick request with the
// processor free first scans: a scan token walks the chain of slot cells
// one cell per cycle, each cell keeping the better of its own job and the
// candidate from its left neighbor, and the last cell's winner, if any, is
// dispatched in the execute state before busy drops.
// Every tick request gives exactly one result, shown with out_valid for one
// cycle; the receiver cannot stall it, and busy stays high until the result
// has been registered, so the next request can be taken while it is shown.
module shortest_job_first_scheduler_core import sjf_pkg::*; #(
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  sjf_req_t in_req,
  output logic     out_valid,
  output sjf_res_t out_res
);

  localparam int SW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int JCW = $clog2(MAX_JOBS + 1);

  sjf_state_t state_r, state_nxt;

  logic [JCW-1:0] job_count_r, job_count_nxt;
  logic [JCW-1:0] unfinished_r, unfinished_nxt;
  logic [15:0]    now_r, now_nxt;
  logic           cpu_busy_r, cpu_busy_nxt;
  logic [SW-1:0]  run_slot_r, run_slot_nxt;
  logic [15:0]    run_rem_r, run_rem_nxt;
  logic [7:0]     run_id_r, run_id_nxt;
  logic           ever_r, ever_nxt;
  logic [7:0]     prev_id_r, prev_id_nxt;
  logic [15:0]    switches_r, switches_nxt;
  logic           out_valid_r, out_valid_nxt;
  sjf_res_t       out_res_r, out_res_nxt;

  logic          accept;
  logic          do_load;
  logic          scan_launch;
  logic          completing;
  sjf_cell_ctl_t cell_ctl;

  // Chain taps between cells.
  logic      tok   [0:MAX_JOBS];
  sjf_cand_t cand  [0:MAX_JOBS];
  logic [SW-1:0] slot [0:MAX_JOBS];

  // Request decode.
  assign accept      = start && !busy;
  assign do_load     = accept && (in_req.req_type == REQ_LOAD) &&
                       (job_count_r < JCW'(MAX_JOBS));
  assign scan_launch = accept && (in_req.req_type == REQ_TICK) && !cpu_busy_r;

  assign cell_ctl.load_en   = do_load;
  assign cell_ctl.finish_en = completing;

  assign tok[0]  = scan_launch;
  assign cand[0] = '0;
  assign slot[0] = '0;

  // Row of slot cells.
  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    sjf_cell #(
      .SLOT_W  (SW),
      .SLOT_IDX(g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .load_slot  (job_count_r[SW-1:0]),
      .finish_slot(run_slot_nxt),
      .load_req   (in_req),
      .now        (now_r),
      .tok_in     (tok[g]),
      .cand_in    (cand[g]),
      .slot_in    (slot[g]),
      .tok_out    (tok[g+1]),
      .cand_out   (cand[g+1]),
      .slot_out   (slot[g+1])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_req.req_type == REQ_TICK) begin
          state_nxt = cpu_busy_r ? ST_EXEC : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[MAX_JOBS]) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: busy = 1'b1;
      ST_EXEC: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // Dispatch, run one tick and build the result.
  always_comb begin
    logic           exec;
    logic           fresh;
    logic           running;
    logic [15:0]    rem;
    logic [15:0]    tick_end;

    exec           = (state_r == ST_EXEC);
    fresh          = exec && !cpu_busy_r && cand[MAX_JOBS].valid;
    running        = cpu_busy_r || fresh;
    rem            = fresh ? cand[MAX_JOBS].burst : run_rem_r;
    tick_end       = (now_r == TIME_MAX) ? now_r : now_r + 16'd1;

    job_count_nxt  = do_load ? job_count_r + JCW'(1) : job_count_r;
    now_nxt        = now_r;
    cpu_busy_nxt   = cpu_busy_r;
    run_slot_nxt   = fresh ? slot[MAX_JOBS] : run_slot_r;
    run_rem_nxt    = run_rem_r;
    run_id_nxt     = fresh ? cand[MAX_JOBS].id : run_id_r;
    ever_nxt       = ever_r || fresh;
    prev_id_nxt    = fresh ? cand[MAX_JOBS].id : prev_id_r;
    switches_nxt   = switches_r;
    completing     = 1'b0;
    out_valid_nxt  = exec;
    out_res_nxt    = out_res_r;

    if (fresh && ever_r && prev_id_r != cand[MAX_JOBS].id &&
        switches_r != SWITCH_MAX) begin
      switches_nxt = switches_r + 16'd1;
    end

    out_res_nxt.event_kind = EV_IDLE;
    out_res_nxt.run_id     = 8'd0;
    out_res_nxt.dispatched = fresh;
    out_res_nxt.ticks_left = 16'd0;

    if (exec) begin
      now_nxt = tick_end;
      if (running) begin
        out_res_nxt.run_id = run_id_nxt;
        if (rem > 16'd1) begin
          run_rem_nxt            = rem - 16'd1;
          cpu_busy_nxt           = 1'b1;
          out_res_nxt.event_kind = EV_RUN;
          out_res_nxt.ticks_left = rem - 16'd1;
        end else begin
          run_rem_nxt            = 16'd0;
          cpu_busy_nxt           = 1'b0;
          completing             = 1'b1;
          out_res_nxt.event_kind = EV_DONE;
        end
      end else begin
        cpu_busy_nxt = 1'b0;
      end
    end

    unfinished_nxt = unfinished_r + (do_load ? JCW'(1) : JCW'(0))
                     - (completing ? JCW'(1) : JCW'(0));

    out_res_nxt.tick_start   = now_r;
    out_res_nxt.tick_end     = tick_end;
    out_res_nxt.switch_count = switches_nxt;
    out_res_nxt.all_done     = (unfinished_nxt == '0);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      job_count_r  <= '0;
      unfinished_r <= '0;
      now_r        <= '0;
      cpu_busy_r   <= 1'b0;
      run_slot_r   <= '0;
      ever_r       <= 1'b0;
      prev_id_r    <= '0;
      switches_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      job_count_r  <= job_count_nxt;
      unfinished_r <= unfinished_nxt;
      now_r        <= now_nxt;
      cpu_busy_r   <= cpu_busy_nxt;
      run_slot_r   <= run_slot_nxt;
      ever_r       <= ever_nxt;
      prev_id_r    <= prev_id_nxt;
      switches_r   <= switches_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    run_rem_r <= run_rem_nxt;
    run_id_r  <= run_id_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // A result appears only in the cycle after the execute step.
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC))
    else $error("result shown without an execute step");

  // A job holding the processor is counted as unfinished.
  a_busy_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    cpu_busy_r |-> (unfinished_r != '0))
    else $error("processor busy with no unfinished job");

  // Unfinished jobs never outnumber loaded jobs, which never exceed MAX_JOBS.
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    (unfinished_r <= job_count_r) && (job_count_r <= JCW'(MAX_JOBS)))
    else $error("job counters out of order");

  // Time moves only on an execute step.
  a_time_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_EXEC) |=> $stable(now_r))
    else $error("time changed outside an execute step");

endmodule

FILE: src/sjf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_cell
// One table slot of the scheduler, with one stage of the selection chain.
// ----------------------------------------------------------------------------
module sjf_cell import sjf_pkg::*; #(
  parameter int SLOT_W   = 4,
  parameter int SLOT_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sjf_cell_ctl_t     ctl,
  input  logic [SLOT_W-1:0] load_slot,
  input  logic [SLOT_W-1:0] finish_slot,
  input  sjf_req_t          load_req,
  input  logic [15:0]       now,
  input  logic              tok_in,
  input  sjf_cand_t         cand_in,
  input  logic [SLOT_W-1:0] slot_in,
  output logic              tok_out,
  output sjf_cand_t         cand_out,
  output logic [SLOT_W-1:0] slot_out
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT_IDX);

  logic              loaded_r;
  logic              finished_r;
  logic [7:0]        id_r;
  logic [15:0]       arrival_r;
  logic [15:0]       burst_r;
  logic              tok_r;
  sjf_cand_t         cand_r;
  logic [SLOT_W-1:0] slot_r;

  sjf_cand_t own;
  logic      take_own;

  // Slot status flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r   <= 1'b0;
      finished_r <= 1'b0;
    end else if (ctl.load_en && load_slot == MY_SLOT) begin
      loaded_r   <= 1'b1;
      finished_r <= 1'b0;
    end else if (ctl.finish_en && finish_slot == MY_SLOT) begin
      finished_r <= 1'b1;
    end
  end

  // Job fields, written once by a load.
  always_ff @(posedge clk) begin
    if (ctl.load_en && load_slot == MY_SLOT) begin
      id_r      <= load_req.job_id;
      arrival_r <= load_req.arrival_time;
      burst_r   <= load_req.burst_time;
    end
  end

  // This slot competes when it is loaded, unfinished and has arrived. An
  // incoming candidate comes from a lower slot, so it keeps equal ties.
  always_comb begin
    own.valid   = loaded_r && !finished_r && (arrival_r <= now);
    own.burst   = burst_r;
    own.arrival = arrival_r;
    own.id      = id_r;
    take_own    = own.valid && (!cand_in.valid || sjf_better(own, cand_in));
  end

  // Scan token moves one cell per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

  // Best candidate so far, handed to the next cell.
  always_ff @(posedge clk) begin
    if (tok_in) begin
      if (take_own) begin
        cand_r <= own;
        slot_r <= MY_SLOT;
      end else begin
        cand_r <= cand_in;
        slot_r <= slot_in;
      end
    end
  end

  assign tok_out  = tok_r;
  assign cand_out = cand_r;
  assign slot_out = slot_r;

endmodule

FILE: tb/sv/sjf_sched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_sched_checker
// Watches the request and result channels of the shortest-job-first
// scheduler core. It keeps its own copy of the job table and the processor
// state, predicts the result of every accepted tick request, and compares
// each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sjf_sched_checker import sjf_pkg::*; #(
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  sjf_req_t in_req,
  input  logic     out_valid,
  input  sjf_res_t out_res,
  output int       fail_count,
  output int       pending_count
);

  // Shadow job table.
  logic [7:0]  job_tag    [MAX_JOBS];
  logic [15:0] job_arrive [MAX_JOBS];
  logic [15:0] job_len    [MAX_JOBS];
  logic [15:0] job_left   [MAX_JOBS];
  logic        job_over   [MAX_JOBS];
  int unsigned jobs_held;

  // Shadow processor state.
  logic [15:0] sim_now;
  int unsigned active_slot;
  logic        cpu_taken;
  logic        had_dispatch;
  logic [7:0]  last_tag;
  logic [15:0] switch_tally;

  // Results predicted for accepted tick requests, oldest first.
  sjf_res_t    tick_results_q[$];
  sjf_res_t    want;
  int          mismatches = 0;

  assign fail_count = mismatches;

  // True when slot a beats slot b: shorter burst, earlier arrival, lower id.
  function automatic logic outranks(int unsigned a, int unsigned b);
    if (job_len[a] != job_len[b]) return job_len[a] < job_len[b];
    if (job_arrive[a] != job_arrive[b]) return job_arrive[a] < job_arrive[b];
    return job_tag[a] < job_tag[b];
  endfunction

  task automatic clear_model();
    int unsigned i;
    for (i = 0; i < MAX_JOBS; i++) begin
      job_over[i] = 1'b0;
    end
    jobs_held    = 0;
    sim_now      = '0;
    active_slot  = 0;
    cpu_taken    = 1'b0;
    had_dispatch = 1'b0;
    last_tag     = '0;
    switch_tally = '0;
  endtask

  // A load fills the next free slot; a full table drops it.
  task automatic store_job(input sjf_req_t r);
    if (jobs_held < MAX_JOBS) begin
      job_tag[jobs_held]    = r.job_id;
      job_arrive[jobs_held] = r.arrival_time;
      job_len[jobs_held]    = r.burst_time;
      job_left[jobs_held]   = r.burst_time;
      job_over[jobs_held]   = 1'b0;
      jobs_held++;
    end
  endtask

  // Advance the shadow scheduler by one tick and build the expected result.
  task automatic predict_tick(output sjf_res_t res);
    int unsigned i;
    int unsigned pick;
    logic        found;
    logic [15:0] t_end;
    logic        all_over;
    pick  = 0;
    found = 1'b0;
    res   = '0;
    t_end = (sim_now == TIME_MAX) ? sim_now : sim_now + 16'd1;

    // Pick the best arrived, unfinished job only when the processor is free.
    if (!cpu_taken) begin
      for (i = 0; i < jobs_held; i++) begin
        if (!job_over[i] && job_arrive[i] <= sim_now) begin
          if (!found || outranks(i, pick)) begin
            pick  = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        active_slot    = pick;
        cpu_taken      = 1'b1;
        res.dispatched = 1'b1;
        if (had_dispatch && last_tag != job_tag[pick] && switch_tally != SWITCH_MAX) begin
          switch_tally++;
        end
        last_tag     = job_tag[pick];
        had_dispatch = 1'b1;
      end
    end

    // Run the holder of the processor for one tick.
    if (!cpu_taken) begin
      res.event_kind = EV_IDLE;
    end else begin
      res.run_id = job_tag[active_slot];
      if (job_left[active_slot] > 16'd1) begin
        job_left[active_slot] = job_left[active_slot] - 16'd1;
        res.ticks_left = job_left[active_slot];
        res.event_kind = EV_RUN;
      end else begin
        job_left[active_slot] = '0;
        job_over[active_slot] = 1'b1;
        cpu_taken      = 1'b0;
        res.event_kind = EV_DONE;
      end
    end

    res.tick_start   = sim_now;
    res.tick_end     = t_end;
    sim_now          = t_end;
    res.switch_count = switch_tally;
    all_over = 1'b1;
    for (i = 0; i < jobs_held; i++) begin
      if (!job_over[i]) all_over = 1'b0;
    end
    res.all_done = all_over;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Results are compared before the request of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      tick_results_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (tick_results_q.size() == 0) begin
          $error("result strobed with no tick request outstanding");
          mismatches++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("event_kind", 16'(want.event_kind), 16'(out_res.event_kind));
          check_field("run_id", 16'(want.run_id), 16'(out_res.run_id));
          check_field("dispatched", 16'(want.dispatched), 16'(out_res.dispatched));
          check_field("ticks_left", want.ticks_left, out_res.ticks_left);
          check_field("tick_start", want.tick_start, out_res.tick_start);
          check_field("tick_end", want.tick_end, out_res.tick_end);
          check_field("switch_count", want.switch_count, out_res.switch_count);
          check_field("all_done", 16'(want.all_done), 16'(out_res.all_done));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (in_req.req_type == REQ_LOAD) begin
          store_job(in_req);
        end else begin
          predict_tick(want);
          tick_results_q.insert(tick_results_q.size(), want);
        end
      end
    end
    pending_count <= tick_results_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the shortest-job-first scheduler core.
// A directed opening exercises the tie-breaks, zero bursts and the empty
// table; a random part spreads the remaining loads over a long run of
// ticks; a last part fills the table and tries loads past a full table.
// A checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb import sjf_pkg::*; ();

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  sjf_req_t in_req;
  logic     out_valid;
  sjf_res_t out_res;
  int       fail_count;
  int       pending_count;

  int unsigned ticks_sent = 0;
  int unsigned idle_pct = 28;

  always #5 clk = ~clk;

  shortest_job_first_scheduler_core #(
    .MAX_JOBS(DEF_MAX_JOBS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  sjf_sched_checker #(
    .MAX_JOBS(DEF_MAX_JOBS)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_res      (out_res),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  function automatic sjf_req_t make_req(input logic kind, input logic [7:0] id,
                                        input logic [15:0] arr, input logic [15:0] len);
    sjf_req_t r;
    r.req_type     = kind;
    r.job_id       = id;
    r.arrival_time = arr;
    r.burst_time   = len;
    return r;
  endfunction

  function automatic sjf_req_t noise_req(input logic kind);
    return make_req(kind, 8'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // Idle for a random number of cycles, then hold a request until accepted.
  task automatic send_req(input sjf_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start  <= 1'b0;
      in_req <= noise_req(1'($urandom));
      @(posedge clk);
    end
    in_req <= r;
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.req_type == REQ_TICK) ticks_sent++;
  endtask

  task automatic send_tick();
    send_req(noise_req(REQ_TICK));
  endtask

  task automatic send_load(input logic [7:0] id, input logic [15:0] arr,
                           input logic [15:0] len);
    send_req(make_req(REQ_LOAD, id, arr, len));
  endtask

  // Run-away guard.
  initial begin
    #50_000_000;
    $display("[shortest_job_first_scheduler_core] ERROR");
    $finish;
  end

  initial begin
    int unsigned k;
    int unsigned back;
    int unsigned loads_left;
    logic [15:0] arr;
    logic [15:0] len;

    rst_n  = 1'b0;
    start  = 1'b0;
    in_req = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a tick on an empty table reports idle with all jobs done.
    send_tick();
    // Equal burst and arrival fall to the lower id; a later arrival loses.
    send_load(8'd5, 16'd0, 16'd4);
    send_load(8'd3, 16'd0, 16'd4);
    send_load(8'd9, 16'd1, 16'd4);
    // Two identical jobs fall to the lower slot.
    send_load(8'd7, 16'd0, 16'd1);
    send_load(8'd7, 16'd0, 16'd1);
    // A zero burst that arrives later still completes after one tick.
    send_load(8'd0, 16'd2, 16'd0);
    repeat (3) send_tick();
    // A zero-burst job loaded with the processor free wins the next dispatch.
    send_load(8'd1, 16'd0, 16'd0);
    repeat (12) send_tick();

    // Random: ticks with sparse pairs of loads near the current time.
    loads_left = 6;
    for (k = 0; k < 1700; k++) begin
      idle_pct = (k >= 800 && k < 1000) ? 0 : 28;
      if (k % 560 == 100 && loads_left >= 2) begin
        if ($urandom_range(3) == 0) begin
          back = $urandom_range(0, 50);
          if (back > ticks_sent) back = ticks_sent;
          arr = 16'(ticks_sent - back);
        end else begin
          arr = 16'(ticks_sent + $urandom_range(0, 40));
        end
        len = ($urandom_range(7) == 0) ? 16'($urandom_range(0, 1))
                                        : 16'($urandom_range(0, 120));
        send_load(8'($urandom), arr, len);
        // The partner either ties on burst and arrival or is independent.
        if ($urandom_range(1) == 0) begin
          send_load(8'($urandom), arr, len);
        end else begin
          send_load(8'($urandom), 16'(ticks_sent + $urandom_range(0, 40)),
                    16'($urandom_range(0, 120)));
        end
        loads_left -= 2;
      end else begin
        send_tick();
      end
    end

    // Full table: three short jobs take the last free slots, then loads
    // past a full table are dropped while the last jobs run out.
    idle_pct = 28;
    send_load(8'($urandom), 16'(ticks_sent), 16'd3);
    send_load(8'd200, 16'(ticks_sent), 16'd2);
    send_load(8'd255, 16'(ticks_sent + 5), 16'd0);
    repeat (3) send_req(noise_req(REQ_LOAD));
    repeat (20) send_tick();
    send_req(noise_req(REQ_LOAD));
    repeat (40) send_tick();
    start  <= 1'b0;
    in_req <= noise_req(1'($urandom));

    // Drain outstanding results, then allow the block's scan latency.
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[shortest_job_first_scheduler_core] OK");
    end else begin
      $display("[shortest_job_first_scheduler_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/sjf_pkg.sv
src/sjf_cell.sv
src/shortest_job_first_scheduler_core.sv
tb/sv/sjf_sched_checker.sv
tb/sv/tb.sv
